### rtl/upd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types and constants of the URL path percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

	// longest decoded path, terminator included
	localparam int MAX_PATH = 128;
	localparam int CNT_W    = $clog2(MAX_PATH);

	// characters of interest
	localparam logic [7:0] CH_PERCENT   = 8'h25;
	localparam logic [7:0] CH_PLUS      = 8'h2B;
	localparam logic [7:0] CH_DOT       = 8'h2E;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_NUL       = 8'h00;

	// value added to a letter digit
	localparam logic [3:0] HEX_TEN = 4'd10;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_ESC  = 3'd1,
		ST_INVALID  = 3'd2,
		ST_OVERFLOW = 3'd3,
		ST_UNSAFE   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ESC_NONE = 2'd0,
		ESC_HIGH = 2'd1,
		ESC_LOW  = 2'd2
	} esc_t;

	// one input item
	typedef struct packed {
		logic [7:0] in_byte;
		logic       byte_present;
		logic       last;
	} item_t;

	// one result item
	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_byte_valid;
		logic       done_res;
		status_t    status;
		logic       needs_index;
	} res_t;

	// decoder state carried between items
	typedef struct packed {
		esc_t             esc;
		logic [3:0]       high_nibble;
		logic [CNT_W-1:0] out_count;
		status_t          err_code;
		logic             err_seen;
		logic [1:0]       seg_len;
		logic             seg_all_dots;
		logic             unsafe_seen;
		logic             lead_slashes;
		logic             last_slash;
	} state_t;

	localparam state_t STATE_RESET = '{
		esc:          ESC_NONE,
		high_nibble:  4'd0,
		out_count:    '0,
		err_code:     ST_OK,
		err_seen:     1'b0,
		seg_len:      2'd0,
		seg_all_dots: 1'b1,
		unsafe_seen:  1'b0,
		lead_slashes: 1'b1,
		last_slash:   1'b0
	};

endpackage

### rtl/upd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_core
// Decoder state register and the single-pass step logic for one item.
// ----------------------------------------------------------------------------
module upd_core import upd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  item_t item,
	input  logic  item_valid,
	input  logic  commit,
	output logic  res_valid,
	output res_t  res
);

	state_t st_q;
	state_t nxt;
	logic       have;
	logic       emit;
	logic [7:0] ch;
	logic       hex_ok;
	logic [3:0] hex_val;
	logic [7:0] b;

	assign b = item.in_byte;

	// hex digit in either case
	always_comb begin
		hex_ok  = 1'b1;
		hex_val = 4'd0;
		if (b inside {[8'h30:8'h39]}) begin
			hex_val = b[3:0];
		end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
			hex_val = b[3:0] - 4'd1 + HEX_TEN;
		end else begin
			hex_ok = 1'b0;
		end
	end

	// one step of the decoder
	always_comb begin
		nxt  = st_q;
		have = 1'b0;
		emit = 1'b0;
		ch   = CH_NUL;
		res  = '0;

		if (item.byte_present && !st_q.err_seen &&
		    !(st_q.lead_slashes && st_q.esc == ESC_NONE && b == CH_SLASH)) begin
			nxt.lead_slashes = 1'b0;
			case (st_q.esc)
				ESC_NONE: begin
					if (b == CH_PERCENT) begin
						nxt.esc = ESC_HIGH;
					end else if (b == CH_NUL) begin
						nxt.err_seen = 1'b1;
						nxt.err_code = ST_INVALID;
					end else begin
						ch   = (b == CH_PLUS) ? CH_SPACE : b;
						have = 1'b1;
					end
				end
				ESC_HIGH: begin
					if (!hex_ok) begin
						nxt.err_seen = 1'b1;
						nxt.err_code = ST_BAD_ESC;
					end else begin
						nxt.high_nibble = hex_val;
						nxt.esc         = ESC_LOW;
					end
				end
				default: begin
					if (!hex_ok) begin
						nxt.err_seen = 1'b1;
						nxt.err_code = ST_BAD_ESC;
					end else begin
						ch      = {st_q.high_nibble, hex_val};
						nxt.esc = ESC_NONE;
						have    = 1'b1;
					end
				end
			endcase

			// checks on the decoded character and segment tracking
			if (have) begin
				if (ch == CH_NUL || ch == CH_BACKSLASH) begin
					nxt.err_seen = 1'b1;
					nxt.err_code = ST_INVALID;
				end else if (st_q.out_count >= CNT_W'(MAX_PATH - 1)) begin
					nxt.err_seen = 1'b1;
					nxt.err_code = ST_OVERFLOW;
				end else begin
					emit           = 1'b1;
					nxt.out_count  = st_q.out_count + CNT_W'(1);
					nxt.last_slash = (ch == CH_SLASH);
					if (ch == CH_SLASH) begin
						if (st_q.seg_all_dots && (st_q.seg_len == 2'd1 || st_q.seg_len == 2'd2))
							nxt.unsafe_seen = 1'b1;
						nxt.seg_len      = 2'd0;
						nxt.seg_all_dots = 1'b1;
					end else begin
						if (st_q.seg_len != 2'd3)
							nxt.seg_len = st_q.seg_len + 2'd1;
						if (ch != CH_DOT)
							nxt.seg_all_dots = 1'b0;
					end
				end
			end
		end

		res.out_byte       = emit ? ch : CH_NUL;
		res.out_byte_valid = emit;
		res.done_res       = item.last;

		// end of path: final status, then back to the reset state
		if (item.last) begin
			if (!nxt.err_seen && nxt.esc != ESC_NONE) begin
				nxt.err_seen = 1'b1;
				nxt.err_code = ST_BAD_ESC;
			end
			if (nxt.seg_all_dots && (nxt.seg_len == 2'd1 || nxt.seg_len == 2'd2))
				nxt.unsafe_seen = 1'b1;
			if (nxt.err_seen)
				res.status = nxt.err_code;
			else if (nxt.unsafe_seen)
				res.status = ST_UNSAFE;
			else
				res.status = ST_OK;
			res.needs_index = (res.status == ST_OK) &&
			                  (nxt.out_count == '0 || nxt.last_slash);
			nxt = STATE_RESET;
		end
	end

	assign res_valid = item_valid && (emit || item.last);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RESET;
		end else if (commit) begin
			st_q <= nxt;
		end
	end

endmodule

### rtl/url_path_percent_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_path_percent_decoder
// Percent decoder for URL paths with error, segment and index reporting.
// ----------------------------------------------------------------------------
// Path: input register, then decode logic, then result register.
// Throughput: one item per cycle, set by the single-pass decode step,
// while out_stall does not hold a result in the result register.
// Reset: arst_n clears all control state and the decoder returns to the
// start of a path; the decoder also returns there after each last item.
module url_path_percent_decoder import upd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       byte_present,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_byte_valid,
	output logic       done_res,
	output logic [2:0] status,
	output logic       needs_index
);

	item_t item_s1;
	logic  valid_s1;
	res_t  res_s2;
	logic  valid_s2;
	res_t  res;
	logic  res_valid;
	logic  slot_free;
	logic  advance;
	logic  accept;

	// flow control between input register and result register
	assign slot_free = !valid_s2 || !out_stall;
	assign advance   = valid_s1 && (!res_valid || slot_free);
	assign in_stall  = valid_s1 && !advance;
	assign accept    = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.in_byte      <= in_byte;
			item_s1.byte_present <= byte_present;
			item_s1.last         <= last;
		end
	end

	// decode step
	upd_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_s1),
		.item_valid (valid_s1),
		.commit     (advance),
		.res_valid  (res_valid),
		.res        (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && res_valid) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_s2 <= res;
		end
	end

	assign out_valid      = valid_s2;
	assign out_byte       = res_s2.out_byte;
	assign out_byte_valid = res_s2.out_byte_valid;
	assign done_res       = res_s2.done_res;
	assign status         = res_s2.status;
	assign needs_index    = res_s2.needs_index;

endmodule

### tb/sv/url_path_percent_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_path_percent_decoder_test
// Drives raw URL path bytes into the decoder with random gaps and output
// stalls. A predictor of its own decodes every accepted item, and each
// result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module url_path_percent_decoder_test import upd_pkg::*; ();

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_REPORTS  = 100;
	localparam int HOLD_CYCLES  = 80;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       byte_present;
	logic       last;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       out_byte_valid;
	logic       done_res;
	logic [2:0] status;
	logic       needs_index;

	// decoder state as predicted
	esc_t       esc_ph;
	logic [3:0] hi_nib;
	int         out_cnt;
	status_t    err_code;
	bit         err_seen;
	int         seg_len;
	bit         seg_dots;
	bit         unsafe;
	bit         lead_slash;
	bit         last_slash;

	res_t decoded_fifo[$];
	int   mismatches;
	int   items_sent;
	int   cycle_count;
	int   hold_left;
	int   hold_req;
	int   hold_seen;
	bit   tx_steady;
	bit   rx_steady;

	url_path_percent_decoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.byte_present(byte_present),
		.last(last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.out_byte_valid(out_byte_valid),
		.done_res(done_res),
		.status(status),
		.needs_index(needs_index)
	);

	// clock, 12 ns period
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	function automatic void clear_decoder();
		esc_ph     = ESC_NONE;
		hi_nib     = 4'd0;
		out_cnt    = 0;
		err_code   = ST_OK;
		err_seen   = 1'b0;
		seg_len    = 0;
		seg_dots   = 1'b1;
		unsafe     = 1'b0;
		lead_slash = 1'b1;
		last_slash = 1'b0;
	endfunction

	function automatic int nibble_value(input logic [7:0] b);
		if (b >= "0" && b <= "9") return int'(b - "0");
		if (b >= "a" && b <= "f") return int'(b - "a") + 10;
		if (b >= "A" && b <= "F") return int'(b - "A") + 10;
		return -1;
	endfunction

	function automatic void latch_error(input status_t code);
		if (!err_seen) begin
			err_seen = 1'b1;
			err_code = code;
		end
	endfunction

	// a lone dot or double dot segment makes the path unsafe
	function automatic void close_segment();
		if (seg_dots && (seg_len == 1 || seg_len == 2))
			unsafe = 1'b1;
		seg_len  = 0;
		seg_dots = 1'b1;
	endfunction

	// decode one item, returns 1 when it yields a result
	function automatic bit decode_char(input item_t it, output res_t r);
		bit         have;
		bit         emit;
		logic [7:0] ch;
		int         v;
		status_t    st;
		have = 1'b0;
		emit = 1'b0;
		ch   = 8'h00;
		st   = ST_OK;
		if (it.byte_present && !err_seen) begin
			if (!(lead_slash && esc_ph == ESC_NONE && it.in_byte == CH_SLASH)) begin
				lead_slash = 1'b0;
				if (esc_ph == ESC_NONE) begin
					if (it.in_byte == CH_PERCENT)
						esc_ph = ESC_HIGH;
					else if (it.in_byte == CH_NUL)
						latch_error(ST_INVALID);
					else begin
						ch   = (it.in_byte == CH_PLUS) ? CH_SPACE : it.in_byte;
						have = 1'b1;
					end
				end else begin
					v = nibble_value(it.in_byte);
					if (v < 0)
						latch_error(ST_BAD_ESC);
					else if (esc_ph == ESC_HIGH) begin
						hi_nib = v[3:0];
						esc_ph = ESC_LOW;
					end else begin
						ch     = {hi_nib, v[3:0]};
						esc_ph = ESC_NONE;
						have   = 1'b1;
					end
				end
				// decoded byte checks, then segment tracking
				if (have) begin
					if (ch == CH_NUL || ch == CH_BACKSLASH)
						latch_error(ST_INVALID);
					else if (out_cnt + 1 >= MAX_PATH)
						latch_error(ST_OVERFLOW);
					else begin
						emit       = 1'b1;
						out_cnt    = out_cnt + 1;
						last_slash = (ch == CH_SLASH);
						if (ch == CH_SLASH)
							close_segment();
						else begin
							if (seg_len < 3) seg_len = seg_len + 1;
							if (ch != CH_DOT) seg_dots = 1'b0;
						end
					end
				end
			end
		end
		if (!emit && !it.last) return 1'b0;
		if (it.last) begin
			if (!err_seen && esc_ph != ESC_NONE) latch_error(ST_BAD_ESC);
			close_segment();
			if (err_seen) st = err_code;
			else if (unsafe) st = ST_UNSAFE;
		end
		r.out_byte       = emit ? ch : 8'h00;
		r.out_byte_valid = emit;
		r.done_res       = it.last;
		r.status         = st;
		r.needs_index    = it.last && st == ST_OK && (out_cnt == 0 || last_slash);
		if (it.last) clear_decoder();
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	// compare each accepted result with the oldest prediction
	always @(posedge clk) begin : check_out
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (decoded_fifo.size() == 0)
				report_mismatch("result with no prediction waiting");
			else begin
				want = decoded_fifo.pop_front();
				check_field("out_byte", out_byte, want.out_byte);
				check_field("out_byte_valid", 8'(out_byte_valid),
					8'(want.out_byte_valid));
				check_field("done_res", 8'(done_res), 8'(want.done_res));
				check_field("status", 8'(status), 8'(want.status));
				check_field("needs_index", 8'(needs_index), 8'(want.needs_index));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("url_path_percent_decoder_test failed");
			$finish;
		end
	end

	// receiver stalls, with a counted hold-off when one is requested
	always @(negedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left--;
		end else if (rx_steady)
			out_stall = 1'b0;
		else
			out_stall = ($urandom_range(99) < 30);
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------

	// send one item, entered and left at a falling edge
	task automatic send_item(input logic [7:0] b, input logic p, input logic l);
		item_t it;
		res_t  r;
		it.in_byte      = b;
		it.byte_present = p;
		it.last         = l;
		if (!tx_steady) begin
			while ($urandom_range(99) < 30) begin
				in_valid     = 1'b0;
				in_byte      = 8'($urandom_range(255));
				byte_present = 1'($urandom_range(1));
				last         = 1'($urandom_range(1));
				@(negedge clk);
			end
		end
		in_valid     = 1'b1;
		in_byte      = b;
		byte_present = p;
		last         = l;
		do @(posedge clk); while (in_stall);
		if (decode_char(it, r)) decoded_fifo.push_back(r);
		items_sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// whole path, last on its final character
	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b1, i == s.len() - 1);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 10) return "0" + nib;
		return 8'(($urandom_range(1) ? "A" : "a") + nib - 10);
	endfunction

	// random path: mostly well-formed text, escapes and separators with noise
	task automatic send_random_path(input int min_len, input int max_len, input bit clean);
		logic [7:0] txt[$];
		string      letters;
		int         n;
		int         r;
		bit         marker;
		logic [7:0] val;
		letters = "abzAZ09-_~";
		n = $urandom_range(max_len, min_len);
		while (txt.size() < n) begin
			r = clean ? 0 : $urandom_range(99);
			if (r < 40)
				txt.push_back(letters[$urandom_range(letters.len() - 1)]);
			else if (r < 55)
				txt.push_back(CH_SLASH);
			else if (r < 65)
				txt.push_back(CH_DOT);
			else if (r < 70)
				txt.push_back(CH_PLUS);
			else if (r < 85) begin
				// well-formed escape, often of a byte that matters
				case ($urandom_range(5))
					0: val = CH_SLASH;
					1: val = CH_DOT;
					2: val = CH_NUL;
					3: val = CH_BACKSLASH;
					default: val = 8'($urandom_range(255));
				endcase
				txt.push_back(CH_PERCENT);
				txt.push_back(hex_char(val[7:4]));
				txt.push_back(hex_char(val[3:0]));
			end else if (r < 92) begin
				// broken or cut escape
				txt.push_back(CH_PERCENT);
				repeat ($urandom_range(2)) txt.push_back(8'($urandom_range(255)));
			end else
				txt.push_back(8'($urandom_range(255)));
		end
		marker = (txt.size() == 0) || ($urandom_range(7) == 0);
		for (int k = 0; k < txt.size(); k++) begin
			if (!clean && $urandom_range(19) == 0)
				send_item(8'($urandom_range(255)), 1'b0, 1'b0);
			send_item(txt[k], 1'b1, !marker && k == txt.size() - 1);
		end
		if (marker) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// empty paths, skipped leading slashes, dot segment, decoded slash
	task automatic test_slashes_and_empty();
		send_item(8'h00, 1'b0, 1'b1);
		send_text("//.");
		send_text("%2f");
	endtask

	// plus, mixed-case hex, raw top byte after a marker with no effect
	task automatic test_escape_decoding();
		send_text("+%Ff");
		send_item(8'hA5, 1'b0, 1'b0);
		send_item(8'hFF, 1'b1, 1'b1);
	endtask

	// raw zero, non-hex in escape, decoded backslash, path cut inside escape
	task automatic test_error_cases();
		send_item(CH_NUL, 1'b1, 1'b0);
		send_item("a", 1'b1, 1'b1);
		send_text("%g");
		send_text("%5C");
		send_text("%4");
	endtask

	// output length around the limit
	task automatic test_overflow();
		send_random_path(MAX_PATH - 1, MAX_PATH - 1, 1'b1);
		send_random_path(MAX_PATH, MAX_PATH, 1'b1);
		send_random_path(MAX_PATH + 4, MAX_PATH + 12, 1'b1);
	endtask

	task automatic test_random_paths();
		int target;
		target = items_sent + 200;
		while (items_sent < target)
			send_random_path(0, ($urandom_range(39) == 0) ? 140 : 16, 1'b0);
	endtask

	// no idling on either side
	task automatic test_streaming();
		int target;
		target = items_sent + 80;
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		while (items_sent < target)
			send_random_path(0, 16, 1'b0);
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// receiver holds off while the sender keeps offering items
	task automatic test_output_hold();
		int target;
		target = items_sent + 40;
		tx_steady = 1'b1;
		hold_req++;
		while (items_sent < target)
			send_random_path(4, 16, 1'b0);
		tx_steady = 1'b0;
	endtask

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_byte      = 8'h00;
		byte_present = 1'b0;
		last         = 1'b0;
		items_sent   = 0;
		hold_req     = 0;
		tx_steady    = 1'b0;
		rx_steady    = 1'b0;
		clear_decoder();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_slashes_and_empty();
		test_escape_decoding();
		test_error_cases();
		test_overflow();
		test_random_paths();
		test_streaming();
		test_output_hold();

		// drain, then allow for stray results
		while (decoded_fifo.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("url_path_percent_decoder_test passed");
		else
			$display("url_path_percent_decoder_test failed");
		$finish;
	end

endmodule

### url_path_percent_decoder.f
rtl/upd_pkg.sv
rtl/upd_core.sv
rtl/url_path_percent_decoder.sv
tb/sv/url_path_percent_decoder_test.sv
